[src/mpcw_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the motor command to PWM channel writer.
// No dependencies; every other file in src imports this package.
package mpcw_pkg;

    // Motor configuration
    localparam int MOTOR_COUNT_DEF = 4;
    localparam int MOTOR_IDX_W     = 2;

    // Command kinds
    localparam logic [1:0] KIND_SET      = 2'd0;
    localparam logic [1:0] KIND_STOP     = 2'd1;
    localparam logic [1:0] KIND_STOP_ALL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLED     = 2'd0;
    localparam logic [1:0] CFG_INVERT_MASK = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_MAP = 2'd2;

    localparam logic [47:0] CHANNEL_MAP_RESET = 48'hA9B786543120;

    // Expander encoding
    localparam logic [12:0] FULL_COUNT = 13'd4096;
    localparam logic [11:0] DUTY_MAX   = 12'd4095;
    localparam logic [6:0]  BASE_ADDR  = 7'd6;
    localparam logic [6:0]  SPEED_MAX  = 7'd100;

    // Divide by 100 as multiply by ceil(2^26 / 100), then shift by 26
    localparam int          RECIP_SHIFT = 26;
    localparam logic [19:0] RECIP_100   = 20'd671089;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         motor;
        logic signed [15:0] speed;
        logic               brake;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  register_address;
        logic [12:0] on_count;
        logic [12:0] off_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        enabled;
        logic [3:0]  invert_mask;
        logic [47:0] channel_map;
    } cfg_t;

    // Decoded command, before the duty is known
    typedef struct packed {
        logic                   all_motors;
        logic [MOTOR_IDX_W-1:0] motor_idx;
        logic                   stop;
        logic                   level;
        logic [6:0]             mag;
    } dec_cmd_t;

    // Command ready for the write sequencer
    typedef struct packed {
        logic                   all_motors;
        logic [MOTOR_IDX_W-1:0] motor_idx;
        logic                   stop;
        logic                   level;
        logic [11:0]            duty;
    } wr_cmd_t;

endpackage

[src/mpcw_decode.sv]
`timescale 1ns / 1ps
// Stage 1: validate a command, clamp the speed, and resolve the direction.
// Depends on mpcw_pkg.
module mpcw_decode import mpcw_pkg::*; #(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output dec_cmd_t out_cmd
);

    logic     valid_reg, valid_next;
    dec_cmd_t cmd_reg, cmd_next;
    logic     keep;
    logic     motor_ok;
    logic signed [15:0] speed_clamped;
    logic [MOTOR_IDX_W-1:0] midx;
    logic     inv;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;

    // Check the motor number and pick the command fields
    always_comb begin
        motor_ok = (in_item.motor != 3'd0) && (in_item.motor <= 3'(MOTOR_COUNT));
        midx     = MOTOR_IDX_W'(in_item.motor - 3'd1);
        inv      = cfg.invert_mask[midx];

        if (in_item.speed > 16'sd100) begin
            speed_clamped = 16'sd100;
        end else if (in_item.speed < -16'sd100) begin
            speed_clamped = -16'sd100;
        end else begin
            speed_clamped = in_item.speed;
        end

        cmd_next.all_motors = 1'b0;
        cmd_next.motor_idx  = midx;
        cmd_next.stop       = 1'b1;
        cmd_next.level      = in_item.brake;
        cmd_next.mag        = 7'd0;
        keep                = 1'b0;

        case (in_item.kind)
            KIND_SET: begin
                keep = motor_ok;
                if (speed_clamped == 16'sd0) begin
                    // Zero speed coasts
                    cmd_next.level = 1'b0;
                end else begin
                    cmd_next.stop  = 1'b0;
                    cmd_next.level = (speed_clamped > 16'sd0) ^ inv;
                    cmd_next.mag   = (speed_clamped < 16'sd0) ? 7'(-speed_clamped)
                                                             : 7'(speed_clamped);
                end
            end
            KIND_STOP: begin
                keep = motor_ok;
            end
            KIND_STOP_ALL: begin
                keep                = 1'b1;
                cmd_next.all_motors = 1'b1;
                cmd_next.motor_idx  = '0;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Drop commands that produce no writes
    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid && keep && cfg.enabled;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[src/mpcw_duty.sv]
`timescale 1ns / 1ps
// Stages 2 and 3: duty = mag * 4095 / 100 as two registered multiplies.
// Depends on mpcw_pkg.
module mpcw_duty import mpcw_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dec_cmd_t in_cmd,
    output logic     out_valid,
    input  logic     out_ready,
    output wr_cmd_t  out_cmd
);

    logic     a_valid_reg, a_valid_next;
    dec_cmd_t a_cmd_reg;
    logic [18:0] a_prod_reg, a_prod_next;
    logic     a_ready;

    logic     b_valid_reg, b_valid_next;
    wr_cmd_t  b_cmd_reg, b_cmd_next;
    logic [38:0] quot_full;

    assign out_valid = b_valid_reg;
    assign out_cmd   = b_cmd_reg;
    assign a_ready   = !b_valid_reg || out_ready;
    assign in_ready  = !a_valid_reg || a_ready;

    // Stage 2: scale the magnitude by 4095
    assign a_prod_next = 19'(in_cmd.mag) * 19'd4095;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (in_ready) begin
            a_valid_next = in_valid;
        end
    end

    // Stage 3: divide by 100 through the reciprocal
    always_comb begin
        quot_full             = 39'(a_prod_reg) * 39'(RECIP_100);
        b_cmd_next.all_motors = a_cmd_reg.all_motors;
        b_cmd_next.motor_idx  = a_cmd_reg.motor_idx;
        b_cmd_next.stop       = a_cmd_reg.stop;
        b_cmd_next.level      = a_cmd_reg.level;
        b_cmd_next.duty       = quot_full[RECIP_SHIFT +: 12];
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        if (a_ready) begin
            b_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            a_cmd_reg  <= in_cmd;
            a_prod_reg <= a_prod_next;
        end
        if (a_ready) begin
            b_cmd_reg <= b_cmd_next;
        end
    end

endmodule

[src/mpcw_emit.sv]
`timescale 1ns / 1ps
// Write sequencer: steps one command through its channel writes into the
// output register. Depends on mpcw_pkg.
module mpcw_emit import mpcw_pkg::*; #(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic [47:0] channel_map,
    input  logic      in_valid,
    output logic      in_ready,
    input  wr_cmd_t   in_cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      busy_reg, busy_next;
    wr_cmd_t   cmd_reg;
    logic [1:0] sub_reg, sub_next;
    logic [MOTOR_IDX_W-1:0] mcnt_reg, mcnt_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic      out_load;
    logic      is_last;
    logic      take;
    logic [11:0] map_word;
    logic [3:0]  chan;
    logic        lvl;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_load = busy_reg && (!m_valid_reg || m_ready);
    assign is_last  = (sub_reg == 2'd2) &&
                      (!cmd_reg.all_motors || mcnt_reg == MOTOR_IDX_W'(MOTOR_COUNT - 1));
    assign in_ready = !busy_reg || (out_load && is_last);
    assign take     = in_ready && in_valid;

    // Build the current write: IN1, then IN2, then PWM
    always_comb begin
        map_word = channel_map[12 * mcnt_reg +: 12];
        chan     = map_word[3:0];
        lvl      = cmd_reg.level;
        case (sub_reg)
            2'd0: begin
                chan = map_word[7:4];
                lvl  = cmd_reg.level;
            end
            2'd1: begin
                chan = map_word[11:8];
                lvl  = cmd_reg.stop ? cmd_reg.level : !cmd_reg.level;
            end
            default: begin
                chan = map_word[3:0];
                lvl  = cmd_reg.stop ? cmd_reg.level : 1'b1;
            end
        endcase

        m_data_next.register_address = BASE_ADDR + {1'b0, chan, 2'b00};
        m_data_next.last             = is_last;
        if (sub_reg == 2'd2 && !cmd_reg.stop && cmd_reg.duty < DUTY_MAX) begin
            m_data_next.on_count  = '0;
            m_data_next.off_count = 13'(cmd_reg.duty);
        end else if (lvl) begin
            m_data_next.on_count  = FULL_COUNT;
            m_data_next.off_count = '0;
        end else begin
            m_data_next.on_count  = '0;
            m_data_next.off_count = FULL_COUNT;
        end
    end

    // Advance the write counters, load the next command after the last write
    always_comb begin
        busy_next = busy_reg;
        sub_next  = sub_reg;
        mcnt_next = mcnt_reg;
        if (take) begin
            busy_next = 1'b1;
            sub_next  = 2'd0;
            mcnt_next = in_cmd.all_motors ? '0 : in_cmd.motor_idx;
        end else if (out_load) begin
            if (is_last) begin
                busy_next = 1'b0;
            end else if (sub_reg == 2'd2) begin
                sub_next  = 2'd0;
                mcnt_next = mcnt_reg + 1'b1;
            end else begin
                sub_next = sub_reg + 2'd1;
            end
        end
    end

    // Hold the output transaction until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            sub_reg     <= 2'd0;
            mcnt_reg    <= '0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            sub_reg     <= sub_next;
            mcnt_reg    <= mcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= in_cmd;
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

[src/dc_motor_pwm_channel_writer_core.sv]
`timescale 1ns / 1ps
// Motor command to PWM expander channel writes: a set-speed or stop command
// produces three writes (IN1, IN2, PWM), stop-all produces three per motor
// for MOTOR_COUNT motors, and disabled, out-of-range or unused commands
// produce none. Commands enter a four-stage pipeline (decode, scale by 4095,
// divide by 100, write sequencer) and one can be accepted every cycle while
// the sequencer has room. Sustained throughput is set by the single output
// port, which moves one write per cycle while m_ready is high. The user must
// write configuration registers through cfg_we/cfg_index/cfg_wdata only while
// no transaction is in flight; the block itself does not enforce this.
// Depends on mpcw_pkg, mpcw_decode, mpcw_duty and mpcw_emit.
module dc_motor_pwm_channel_writer_core import mpcw_pkg::*; #(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    cfg_t     cfg_reg;
    logic     dec_valid, dec_ready;
    dec_cmd_t dec_cmd;
    logic     duty_valid, duty_ready;
    wr_cmd_t  duty_cmd;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled     <= 1'b0;
            cfg_reg.invert_mask <= 4'd0;
            cfg_reg.channel_map <= CHANNEL_MAP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENABLED:     cfg_reg.enabled     <= cfg_wdata[0];
                CFG_INVERT_MASK: cfg_reg.invert_mask <= cfg_wdata[3:0];
                CFG_CHANNEL_MAP: cfg_reg.channel_map <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mpcw_decode #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_cmd   (dec_cmd)
    );

    mpcw_duty u_duty (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_cmd    (dec_cmd),
        .out_valid (duty_valid),
        .out_ready (duty_ready),
        .out_cmd   (duty_cmd)
    );

    mpcw_emit #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .channel_map (cfg_reg.channel_map),
        .in_valid    (duty_valid),
        .in_ready    (duty_ready),
        .in_cmd      (duty_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for dc_motor_pwm_channel_writer_core: motor commands in, expander
// channel writes out, each write checked against a built-in predictor.
// Depends on mpcw_pkg and the core RTL in src.
module tb_top;
    import mpcw_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         MOTORS      = 4;
    localparam int         SETTLE      = 16;
    localparam int         DRAIN_LIMIT = 50000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;

    // Predictor copy of the registers and the writes still owed by the block
    cfg_t        model_cfg;
    out_item_t   pending_writes[$];
    out_item_t   want_write;
    int          mismatch_count;

    // Idle controls shared by the drivers
    int          send_idle_pct;
    int          recv_stall_pct;
    int          holdoff_left;
    logic        rdy_next;

    dc_motor_pwm_channel_writer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Clock: 8 ns period
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Count a failure, report only the first ten
    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    function automatic string fmt_write(input out_item_t w);
        return $sformatf("addr %0d on %0d off %0d last %0b",
                         w.register_address, w.on_count, w.off_count, w.last);
    endfunction

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Channel at slot sel (0 pwm, 1 in1, 2 in2) of motor m (from 1)
    function automatic logic [3:0] motor_channel(input int m, input int sel);
        return model_cfg.channel_map[(m - 1) * 12 + sel * 4 +: 4];
    endfunction

    function automatic void push_write(input logic [3:0] ch, input logic [12:0] on_cnt,
                                       input logic [12:0] off_cnt);
        out_item_t w;
        w.register_address = BASE_ADDR + {1'b0, ch, 2'b00};
        w.on_count         = on_cnt;
        w.off_count        = off_cnt;
        w.last             = 1'b0;
        pending_writes.push_back(w);
    endfunction

    function automatic void push_level(input logic [3:0] ch, input logic high);
        if (high) push_write(ch, FULL_COUNT, 13'd0);
        else push_write(ch, 13'd0, FULL_COUNT);
    endfunction

    function automatic void push_stop(input int m, input logic brk);
        push_level(motor_channel(m, 1), brk);
        push_level(motor_channel(m, 2), brk);
        push_level(motor_channel(m, 0), brk);
    endfunction

    // Append the channel writes one command owes
    function automatic void predict_writes(input in_item_t cmd);
        int   start_len;
        int   spd;
        int   duty;
        logic fwd;
        start_len = pending_writes.size();
        if (model_cfg.enabled) begin
            if (cmd.kind == KIND_STOP_ALL) begin
                for (int m = 1; m <= MOTORS; m++) push_stop(m, cmd.brake);
            end else if ((cmd.kind == KIND_SET || cmd.kind == KIND_STOP) &&
                         cmd.motor >= 1 && cmd.motor <= MOTORS) begin
                if (cmd.kind == KIND_STOP) begin
                    push_stop(cmd.motor, cmd.brake);
                end else begin
                    spd = int'($signed(cmd.speed));
                    if (spd > 100) spd = 100;
                    if (spd < -100) spd = -100;
                    if (spd == 0) begin
                        push_stop(cmd.motor, 1'b0);
                    end else begin
                        fwd  = spd > 0;
                        duty = (spd < 0 ? -spd : spd) * 4095 / 100;
                        if (model_cfg.invert_mask[cmd.motor - 1]) fwd = ~fwd;
                        push_level(motor_channel(cmd.motor, 1), fwd);
                        push_level(motor_channel(cmd.motor, 2), ~fwd);
                        if (duty >= 4095) push_level(motor_channel(cmd.motor, 0), 1'b1);
                        else push_write(motor_channel(cmd.motor, 0), 13'd0, 13'(duty));
                    end
                end
            end
        end
        if (pending_writes.size() > start_len)
            pending_writes[pending_writes.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Result side: stall pattern and checker
    // ---------------------------------------------------------------

    // Drive ready: long hold-off first, then random stalls
    always @(negedge aclk) begin
        if (holdoff_left > 0) begin
            rdy_next = 1'b0;
            holdoff_left--;
        end else begin
            rdy_next = $urandom_range(99) >= recv_stall_pct;
        end
        m_ready <= rdy_next;
    end

    // Compare each accepted write with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                note_failure({"unexpected write: ", fmt_write(m_data)});
            end else begin
                want_write = pending_writes.pop_front();
                if (m_data.register_address !== want_write.register_address ||
                    m_data.on_count !== want_write.on_count ||
                    m_data.off_count !== want_write.off_count ||
                    m_data.last !== want_write.last)
                    note_failure({"write mismatch: expected ", fmt_write(want_write),
                                  ", got ", fmt_write(m_data)});
            end
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLED:     model_cfg.enabled     = value[0];
            CFG_INVERT_MASK: model_cfg.invert_mask = value[3:0];
            CFG_CHANNEL_MAP: model_cfg.channel_map = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Offer one command and hold it until the transaction completes
    task automatic send_cmd(input in_item_t cmd);
        int gap;
        gap = 0;
        // Idle each cycle with the phase's probability
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        predict_writes(cmd);
        @(negedge aclk);
    endtask

    function automatic in_item_t make_cmd(input logic [1:0] kind, input logic [2:0] motor,
                                          input int speed, input logic brk);
        in_item_t c;
        c.kind  = kind;
        c.motor = motor;
        c.speed = 16'(speed);
        c.brake = brk;
        return c;
    endfunction

    // Mostly well-formed commands, some out-of-range motors and unused kinds
    function automatic in_item_t rand_cmd();
        in_item_t c;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 55) c.kind = KIND_SET;
        else if (pick < 80) c.kind = KIND_STOP;
        else if (pick < 92) c.kind = KIND_STOP_ALL;
        else c.kind = KIND_UNUSED;
        if ($urandom_range(9) == 0) c.motor = 3'($urandom_range(7));
        else c.motor = 3'($urandom_range(1, 4));
        pick = $urandom_range(9);
        if (pick < 6) c.speed = 16'(int'($urandom_range(240)) - 120);
        else if (pick < 9) c.speed = 16'($urandom);
        else c.speed = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        c.brake = 1'($urandom_range(1));
        return c;
    endfunction

    // Drop valid, wait for every owed write, then let the pipeline settle
    task automatic wait_idle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (pending_writes.size() > 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Random register contents; enable carries random upper bits
    task automatic randomize_config();
        logic [47:0] wide;
        wide = {16'($urandom), 32'($urandom)};
        wide[0] = $urandom_range(7) != 0;
        write_reg(CFG_ENABLED, wide);
        write_reg(CFG_INVERT_MASK, {16'($urandom), 32'($urandom)});
        write_reg(CFG_CHANNEL_MAP, {16'($urandom), 32'($urandom)});
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Out of reset the block is disabled: nothing may come out
    task automatic test_reset_disabled();
        send_cmd(make_cmd(KIND_SET, 3'd1, 50, 1'b0));
        send_cmd(make_cmd(KIND_STOP_ALL, 3'd0, 0, 1'b1));
        send_cmd(make_cmd(KIND_STOP, 3'd2, 0, 1'b0));
        wait_idle();
    endtask

    // Speed extremes, stops, out-of-range motors, unused kind, inversion
    task automatic test_directed();
        write_reg(CFG_ENABLED, 48'd1);
        send_cmd(make_cmd(KIND_SET, 3'd1, 0, 1'b1));
        send_cmd(make_cmd(KIND_SET, 3'd1, 1, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd2, -1, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd3, 100, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd4, -100, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd1, 32767, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd2, -32768, 1'b1));
        send_cmd(make_cmd(KIND_SET, 3'd3, 101, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd4, -101, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd1, 50, 1'b0));
        send_cmd(make_cmd(KIND_STOP, 3'd2, 0, 1'b1));
        send_cmd(make_cmd(KIND_STOP, 3'd3, 0, 1'b0));
        send_cmd(make_cmd(KIND_STOP_ALL, 3'd7, 0, 1'b1));
        send_cmd(make_cmd(KIND_STOP_ALL, 3'd0, 0, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd0, 50, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd5, 50, 1'b0));
        send_cmd(make_cmd(KIND_STOP, 3'd7, 0, 1'b1));
        send_cmd(make_cmd(KIND_UNUSED, 3'd1, 60, 1'b1));
        wait_idle();
        write_reg(CFG_INVERT_MASK, 48'h5);
        send_cmd(make_cmd(KIND_SET, 3'd1, 60, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd2, 60, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd3, -60, 1'b0));
        send_cmd(make_cmd(KIND_SET, 3'd4, -99, 1'b0));
        wait_idle();
    endtask

    // Register extremes, wide values, unknown index
    task automatic test_config_extremes();
        write_reg(CFG_INVERT_MASK, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_CHANNEL_MAP, 48'h0);
        send_cmd(make_cmd(KIND_SET, 3'd2, 75, 1'b0));
        send_cmd(make_cmd(KIND_STOP_ALL, 3'd1, 0, 1'b1));
        wait_idle();
        write_reg(CFG_CHANNEL_MAP, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_INVERT_MASK, 48'hFFFF_FFFF_FFF0);
        write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
        send_cmd(make_cmd(KIND_SET, 3'd4, -33, 1'b0));
        send_cmd(make_cmd(KIND_STOP, 3'd1, 0, 1'b0));
        wait_idle();
        // Wide value with bit zero clear disables the block
        write_reg(CFG_ENABLED, 48'hFFFF_FFFF_FFFE);
        send_cmd(make_cmd(KIND_STOP_ALL, 3'd0, 0, 1'b1));
        send_cmd(make_cmd(KIND_SET, 3'd1, 40, 1'b0));
        wait_idle();
        write_reg(CFG_ENABLED, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_CHANNEL_MAP, CHANNEL_MAP_RESET);
    endtask

    // One random phase with a given idle pattern
    task automatic test_traffic(input int send_pct, input int recv_pct, input int count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        randomize_config();
        repeat (count) send_cmd(rand_cmd());
        wait_idle();
    endtask

    // Hold the result side off for a long stretch so the block backs up
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_ENABLED, 48'd1);
        holdoff_left = 300;
        repeat (40) send_cmd(rand_cmd());
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 0;
        mismatch_count = 0;
        model_cfg.enabled     = 1'b0;
        model_cfg.invert_mask = 4'd0;
        model_cfg.channel_map = CHANNEL_MAP_RESET;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_disabled();
        test_directed();
        test_config_extremes();
        test_traffic(0, 0, 100);
        test_traffic(56, 0, 100);
        test_traffic(0, 56, 100);
        test_traffic(20, 20, 100);
        test_backpressure();

        wait_idle();
        while (pending_writes.size() > 0) begin
            want_write = pending_writes.pop_front();
            note_failure({"missing write: ", fmt_write(want_write)});
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
